### hw/rtl/dxf_pkg.sv
`default_nettype none

package dxf_pkg;

  // Default sizing of the block
  localparam int DEF_CHANNELS_PER_BUS  = 8;
  localparam int DEF_PACKET_DATA_BYTES = 12;
  localparam int DEF_CHANNEL_LIMIT     = 16;

  // Packet framing
  localparam int PREFIX_LEN = 4;

  // Field and register widths
  localparam int INDEX_W    = 9;
  localparam int LEVEL_W    = 8;
  localparam int FRAME_W    = 23;
  localparam int FAST_W     = 16;
  localparam int REFRESH_W  = 20;
  localparam int AGE_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 23;

  // Item kinds on the input stream
  localparam logic FUNC_CHANNEL = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_CLAMP_MAX     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FAST_INTERVAL = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOLDOFF_TIME  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDLE_INTERVAL = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE_HOLD   = 3'd4;

  // Reset values of the configuration registers
  localparam logic [LEVEL_W-1:0]   RST_CLAMP_MAX     = 8'd245;
  localparam logic [FAST_W-1:0]    RST_FAST_INTERVAL = 16'd575;
  localparam logic [FRAME_W-1:0]   RST_HOLDOFF_TIME  = 23'd5000000;
  localparam logic [REFRESH_W-1:0] RST_IDLE_INTERVAL = 20'd500000;
  localparam logic [AGE_W-1:0]     RST_ENABLE_HOLD   = 16'd5000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } dxf_state_t;

  typedef struct packed {
    logic [FAST_W-1:0]    fast_interval;
    logic [FRAME_W-1:0]   holdoff_time;
    logic [REFRESH_W-1:0] idle_interval;
    logic [AGE_W-1:0]     enable_hold;
  } dxf_timer_cfg_t;

  typedef struct packed {
    logic send;
    logic enable_a;
    logic enable_b;
  } dxf_ctrl_t;

  function automatic logic [LEVEL_W-1:0] prefix_byte(input logic [1:0] i);
    logic [LEVEL_W-1:0] b;
    case (i)
      2'd0:    b = 8'd149;
      2'd1:    b = 8'd1;
      2'd2:    b = 8'd250;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/dxf_ram.sv
`default_nettype none

module dxf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/dxf_timers.sv
`default_nettype none

module dxf_timers
  import dxf_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire dxf_timer_cfg_t cfg,
  input  wire logic           tick,
  input  wire logic           frame_mark,
  output dxf_ctrl_t           ctrl
);

  logic                 changed, changed_next;
  logic [FRAME_W-1:0]   since_frame, since_frame_next;
  logic [FAST_W-1:0]    since_fast, since_fast_next;
  logic [REFRESH_W-1:0] since_refresh, since_refresh_next;
  logic                 on_a, on_a_next, on_b, on_b_next;
  logic [AGE_W-1:0]     age_a, age_a_next, age_b, age_b_next;

  logic [FRAME_W-1:0]   frame_inc;
  logic [FAST_W-1:0]    fast_inc;
  logic [REFRESH_W-1:0] refresh_inc;
  logic [AGE_W-1:0]     age_a_inc, age_b_inc;
  logic                 fast_mode, send_now;

  always_comb begin
    // saturating advance of every tick counter
    frame_inc   = (since_frame == '1) ? since_frame : since_frame + 1'b1;
    fast_inc    = (since_fast == '1) ? since_fast : since_fast + 1'b1;
    refresh_inc = (since_refresh == '1) ? since_refresh : since_refresh + 1'b1;
    age_a_inc   = (age_a == '1) ? age_a : age_a + 1'b1;
    age_b_inc   = (age_b == '1) ? age_b : age_b + 1'b1;

    fast_mode = changed || (frame_inc < cfg.holdoff_time);
    send_now  = fast_mode ? (fast_inc >= cfg.fast_interval)
                          : (refresh_inc >= cfg.idle_interval);

    changed_next       = changed;
    since_frame_next   = since_frame;
    since_fast_next    = since_fast;
    since_refresh_next = since_refresh;
    on_a_next          = on_a;
    on_b_next          = on_b;
    age_a_next         = age_a;
    age_b_next         = age_b;

    if (tick) begin
      since_frame_next   = frame_inc;
      since_fast_next    = fast_inc;
      since_refresh_next = refresh_inc;
      age_a_next         = age_a_inc;
      age_b_next         = age_b_inc;
      if (send_now) begin
        if (fast_mode) begin
          changed_next = 1'b0;
        end
        since_fast_next    = '0;
        since_refresh_next = '0;
        on_a_next          = 1'b1;
        on_b_next          = 1'b1;
        age_a_next         = '0;
        age_b_next         = '0;
      end
      // drop check runs after a possible send
      if (on_a_next && (age_a_next >= cfg.enable_hold)) begin
        on_a_next = 1'b0;
      end
      if (on_b_next && (age_b_next >= cfg.enable_hold)) begin
        on_b_next = 1'b0;
      end
    end

    if (frame_mark) begin
      changed_next     = 1'b1;
      since_frame_next = '0;
    end

    ctrl.send     = tick && send_now;
    ctrl.enable_a = on_a_next;
    ctrl.enable_b = on_b_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      changed       <= 1'b0;
      since_frame   <= '0;
      since_fast    <= '0;
      since_refresh <= '0;
      on_a          <= 1'b0;
      on_b          <= 1'b0;
      age_a         <= '0;
      age_b         <= '0;
    end else begin
      changed       <= changed_next;
      since_frame   <= since_frame_next;
      since_fast    <= since_fast_next;
      since_refresh <= since_refresh_next;
      on_a          <= on_a_next;
      on_b          <= on_b_next;
      age_a         <= age_a_next;
      age_b         <= age_b_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dmx_to_dual_bus_packet_framer.sv
`default_nettype none

// DMX to dual bus packet framer. The input stream carries DMX channel levels
// (s_tuser low) and one-microsecond ticks (s_tuser high). Channels below
// CHANNELS_PER_BUS land in bus A's levels, the next CHANNELS_PER_BUS in bus
// B's, each clamped to clamp_max; channels at CHANNEL_LIMIT and above are
// dropped, and s_tlast on a channel item marks a frame end. Every input item
// yields results on the output stream ending with m_tlast high. A channel item
// or a tick that does not send yields one status result (m_tuser bit 0 low)
// carrying the driver enable levels. A sending tick yields a packet of
// PACKET_DATA_BYTES + 5 bytes for bus A and then one for bus B: prefix
// 149,1,250,0, the data bytes, and a checksum mod 256 flagged by m_tuser bit 2.
// A channel item or a non-sending tick is taken whenever the output register
// is free. A sending tick then steps each byte through a read state and an
// emit state, set by the level memory's registered read port; no input is
// taken until the last byte is latched, and output stalls hold the emit
// state. The levels live in a small RAM with one valid flip-flop per entry,
// so reset needs no clearing pass.
// Configuration writes are accepted in every cycle.

module dmx_to_dual_bus_packet_framer
  import dxf_pkg::*;
#(
  parameter int CHANNELS_PER_BUS  = DEF_CHANNELS_PER_BUS,
  parameter int PACKET_DATA_BYTES = DEF_PACKET_DATA_BYTES,
  parameter int CHANNEL_LIMIT     = DEF_CHANNEL_LIMIT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [23:0]           s_tdata,   // channel_index[8:0], channel_value[16:9], zero
  input  wire logic                  s_tuser,   // func
  input  wire logic                  s_tlast,   // frame_end
  // output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [15:0]           m_tdata,   // byte_position[4:0], byte_value[12:5],
                                                // enable_a[13], enable_b[14], zero[15]
  output logic      [2:0]            m_tuser,   // byte_valid[0], bus_select[1], packet_end[2]
  output logic                       m_tlast,   // run_end
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LEVEL_DEPTH = 2 * CHANNELS_PER_BUS;
  localparam int LEVEL_AW    = $clog2(LEVEL_DEPTH);
  localparam int PACKET_LEN  = PREFIX_LEN + PACKET_DATA_BYTES + 1;
  localparam int POS_W       = $clog2(PACKET_LEN + 1);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_LEN - 1);

  // configuration registers
  logic [LEVEL_W-1:0] clamp_max;
  dxf_timer_cfg_t     tcfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_max          <= RST_CLAMP_MAX;
      tcfg.fast_interval <= RST_FAST_INTERVAL;
      tcfg.holdoff_time  <= RST_HOLDOFF_TIME;
      tcfg.idle_interval <= RST_IDLE_INTERVAL;
      tcfg.enable_hold   <= RST_ENABLE_HOLD;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_CLAMP_MAX:     clamp_max          <= cfg_data[LEVEL_W-1:0];
        CFG_FAST_INTERVAL: tcfg.fast_interval <= cfg_data[FAST_W-1:0];
        CFG_HOLDOFF_TIME:  tcfg.holdoff_time  <= cfg_data[FRAME_W-1:0];
        CFG_IDLE_INTERVAL: tcfg.idle_interval <= cfg_data[REFRESH_W-1:0];
        CFG_ENABLE_HOLD:   tcfg.enable_hold   <= cfg_data[AGE_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // input fields
  logic [INDEX_W-1:0] in_index;
  logic [LEVEL_W-1:0] in_value, clamped;
  logic               idx_in_range;

  assign in_index     = s_tdata[8:0];
  assign in_value     = s_tdata[16:9];
  assign clamped      = (in_value > clamp_max) ? clamp_max : in_value;
  assign idx_in_range = (in_index < INDEX_W'(CHANNEL_LIMIT)) &&
                        (in_index < INDEX_W'(LEVEL_DEPTH));

  // timer and send decision
  logic      tick, frame_mark;
  dxf_ctrl_t ctrl;

  dxf_timers u_timers (
    .clk        (clk),
    .rst        (rst),
    .cfg        (tcfg),
    .tick       (tick),
    .frame_mark (frame_mark),
    .ctrl       (ctrl)
  );

  // level memory: bus A at 0..N-1, bus B at N..2N-1, so the channel is the address
  logic                ram_we;
  logic [LEVEL_AW-1:0] wr_addr, rd_addr;
  logic [LEVEL_W-1:0]  rd_data;
  logic [LEVEL_DEPTH-1:0] lvl_set;
  logic                lvl_ok;

  assign wr_addr = in_index[LEVEL_AW-1:0];

  dxf_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (LEVEL_DEPTH)
  ) u_levels (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (clamped),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_set <= '0;
    end else if (ram_we) begin
      lvl_set[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    lvl_ok <= lvl_set[rd_addr];
  end

  // packet sequencer
  dxf_state_t         state, state_next;
  logic               bus, bus_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [LEVEL_W-1:0] sum, sum_next;
  logic [POS_W-1:0]   data_idx;
  logic               in_data;
  logic [LEVEL_W-1:0] byte_val;

  // output register
  logic               out_free, load;
  logic               ld_valid, ld_bus, ld_pend, ld_ena, ld_enb, ld_last;
  logic [4:0]         ld_pos;
  logic [LEVEL_W-1:0] ld_val;

  assign out_free = !m_tvalid || m_tready;
  assign data_idx = pos - POS_W'(PREFIX_LEN);
  assign in_data  = (pos >= POS_W'(PREFIX_LEN)) && (pos < LAST_POS) &&
                    (data_idx < POS_W'(CHANNELS_PER_BUS));

  always_comb begin
    rd_addr = '0;
    if (in_data) begin
      rd_addr = bus ? LEVEL_AW'(data_idx) + LEVEL_AW'(CHANNELS_PER_BUS)
                    : LEVEL_AW'(data_idx);
    end
  end

  always_comb begin
    if (pos < POS_W'(PREFIX_LEN)) begin
      byte_val = prefix_byte(pos[1:0]);
    end else if (pos == LAST_POS) begin
      byte_val = sum;
    end else if (in_data && lvl_ok) begin
      byte_val = rd_data;
    end else begin
      byte_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    bus <= bus_next;
    pos <= pos_next;
    sum <= sum_next;
  end

  always_comb begin
    state_next = state;
    bus_next   = bus;
    pos_next   = pos;
    sum_next   = sum;
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    tick       = 1'b0;
    frame_mark = 1'b0;
    load       = 1'b0;
    ld_valid   = 1'b0;
    ld_bus     = 1'b0;
    ld_pos     = '0;
    ld_val     = '0;
    ld_pend    = 1'b0;
    ld_ena     = ctrl.enable_a;
    ld_enb     = ctrl.enable_b;
    ld_last    = 1'b1;

    unique case (state)
      ST_IDLE: begin
        s_tready = out_free;
        if (s_tvalid && out_free) begin
          if (s_tuser == FUNC_TICK) begin
            tick = 1'b1;
            if (ctrl.send) begin
              // start with bus A, hold status until the packets are out
              state_next = ST_READ;
              bus_next   = 1'b0;
              pos_next   = '0;
              sum_next   = '0;
            end else begin
              load = 1'b1;
            end
          end else begin
            ram_we     = idx_in_range;
            frame_mark = s_tlast;
            load       = 1'b1;
          end
        end
      end
      ST_READ: begin
        // level read is in flight for the current position
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load     = 1'b1;
          ld_valid = 1'b1;
          ld_bus   = bus;
          ld_pos   = 5'(pos);
          ld_val   = byte_val;
          ld_pend  = (pos == LAST_POS);
          ld_ena   = 1'b1;
          ld_enb   = 1'b1;
          ld_last  = (pos == LAST_POS) && bus;
          sum_next = sum + byte_val;
          if (pos == LAST_POS) begin
            if (bus) begin
              state_next = ST_IDLE;
            end else begin
              bus_next   = 1'b1;
              pos_next   = '0;
              sum_next   = '0;
              state_next = ST_READ;
            end
          end else begin
            pos_next   = pos + 1'b1;
            state_next = ST_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output register: fills on load, drains on tready
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {1'b0, ld_enb, ld_ena, ld_val, ld_pos};
      m_tuser <= {ld_pend, ld_bus, ld_valid};
      m_tlast <= ld_last;
    end
  end

endmodule

`default_nettype wire
